@@ rtl/aes_kx_pkg.sv @@
// Shared types, constants and S-box functions for the AES key expansion block.
`default_nettype none

package aes_kx_pkg;

    localparam int SCHEDULE_WORDS_DEF = 60;
    localparam int CFG_IDX_W          = 3;
    localparam int CFG_DATA_W         = 64;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_BYTES = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_01    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_23    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_45    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_67    = 3'd4;

    localparam logic [5:0] KEY_BYTES_128 = 6'd16;
    localparam logic [5:0] KEY_BYTES_192 = 6'd24;
    localparam logic [5:0] KEY_BYTES_256 = 6'd32;
    localparam logic [5:0] KEY_BYTES_RST = KEY_BYTES_128;

    localparam logic [3:0] ROUNDS_128 = 4'd10;
    localparam logic [3:0] ROUNDS_192 = 4'd12;
    localparam logic [3:0] ROUNDS_256 = 4'd14;
    localparam logic [3:0] ROUNDS_BAD = 4'd0;
    localparam logic [3:0] NK_OFFSET  = 4'd6;
    localparam logic [3:0] NK_256     = 4'd8;

    localparam logic REQ_EXPAND = 1'b0;
    localparam logic REQ_READ   = 1'b1;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_BAD_LEN = 2'd1;
    localparam logic [1:0] STATUS_RANGE   = 2'd2;
    localparam logic [1:0] STATUS_NOT_EXP = 2'd3;

    typedef struct packed {
        logic       req_type;
        logic [3:0] round_index;
    } t_req;

    typedef struct packed {
        logic [31:0] round_word0;
        logic [31:0] round_word1;
        logic [31:0] round_word2;
        logic [31:0] round_word3;
        logic [3:0]  round_count;
        logic [1:0]  status;
    } t_result;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_EXPAND,
        S_READ,
        S_RESP
    } t_state;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    // Round constants; entry 0 is never used
    localparam logic [7:0] RCON [16] = '{
        8'h00,8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,
        8'h80,8'h1b,8'h36,8'h00,8'h00,8'h00,8'h00,8'h00
    };

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    function automatic logic [31:0] rot_word(input logic [31:0] w);
        rot_word = {w[23:0], w[31:24]};
    endfunction

endpackage

`default_nettype wire

@@ rtl/aes_key_expansion.sv @@
// AES key expansion for 128, 192 and 256-bit keys with a stored round-key schedule.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+--------------------------
//  in      | input     | i_in_valid / o_in_ready   | i_in  (aes_kx_pkg::t_req)
//  out     | output    | o_out_valid / i_out_ready | o_out (aes_kx_pkg::t_result)
//  cfg     | input     | i_cfg_we, no wait         | i_cfg_index, i_cfg_data
//
// Expand: one schedule word per cycle through a single word unit (RotWord,
// SubWord, Rcon) and the store's one write port: nk key loads, then the computed
// words, then the result moves into the output register.
// Read: four reads from the store's single read port.
// Reset is synchronous, active low; the schedule store is not cleared.
// o_in_ready is high only while idle; a stalled result sits in the output
// register while the next request is taken.
`default_nettype none

module aes_key_expansion #(
    parameter int SCHEDULE_WORDS = aes_kx_pkg::SCHEDULE_WORDS_DEF
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_in_valid,
    output logic                                o_in_ready,
    input  wire  aes_kx_pkg::t_req              i_in,
    output logic                                o_out_valid,
    input  wire                                 i_out_ready,
    output aes_kx_pkg::t_result                 o_out,
    input  wire                                 i_cfg_we,
    input  wire  [aes_kx_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire  [aes_kx_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int ADDR_W = $clog2(SCHEDULE_WORDS);
    localparam int WIDX_W = $clog2(SCHEDULE_WORDS + 1);
    localparam logic [WIDX_W-1:0] DEPTH  = WIDX_W'(SCHEDULE_WORDS);
    localparam logic [7:0]        DEPTH8 = 8'(SCHEDULE_WORDS);

    // configuration registers
    logic [5:0]                        r_key_bytes;
    logic [aes_kx_pkg::CFG_DATA_W-1:0] r_key [4];
    logic                              cfg_hit;

    // sequencer and datapath registers
    aes_kx_pkg::t_state  r_state, n_state;
    logic [WIDX_W-1:0]   r_widx, n_widx;
    logic [WIDX_W-1:0]   r_limit, n_limit;
    logic [WIDX_W-1:0]   r_base, n_base;
    logic [2:0]          r_pos, n_pos;
    logic [2:0]          r_k, n_k;
    logic [3:0]          r_rc_idx, n_rc_idx;
    logic [3:0]          r_nk, n_nk;
    logic [31:0]         r_last, n_last;
    logic [31:0]         r_rdata;
    logic                r_mark, n_mark;
    logic [3:0]          r_rounds, n_rounds;
    aes_kx_pkg::t_result r_res, n_res;
    aes_kx_pkg::t_result r_out, n_out;
    logic                r_out_valid, n_out_valid;

    // schedule store
    logic [31:0]         r_mem [SCHEDULE_WORDS];
    logic                mem_we, mem_re;
    logic [WIDX_W-1:0]   mem_waddr, mem_raddr;
    logic [31:0]         mem_wdata;

    logic [3:0]          nr;
    logic [3:0]          nk_new;
    logic [7:0]          total;
    logic [7:0]          rd_end;
    logic [63:0]         key_pair;
    logic [31:0]         key_word;
    logic [31:0]         t_word;
    logic [31:0]         new_word;
    logic                in_fire;

    always_comb begin
        unique case (r_key_bytes)
            aes_kx_pkg::KEY_BYTES_128: nr = aes_kx_pkg::ROUNDS_128;
            aes_kx_pkg::KEY_BYTES_192: nr = aes_kx_pkg::ROUNDS_192;
            aes_kx_pkg::KEY_BYTES_256: nr = aes_kx_pkg::ROUNDS_256;
            default:                   nr = aes_kx_pkg::ROUNDS_BAD;
        endcase
    end

    assign cfg_hit  = i_cfg_we && (i_cfg_index <= aes_kx_pkg::CFG_KEY_67);
    assign nk_new   = nr - aes_kx_pkg::NK_OFFSET;
    // (rounds + 1) * 4 = 4 * nk + 28
    assign total    = {2'b00, nk_new, 2'b00} + 8'd28;
    assign rd_end   = {2'b00, i_in.round_index, 2'b00} + 8'd4;
    assign in_fire  = i_in_valid && o_in_ready;
    assign key_pair = r_key[r_widx[2:1]];
    assign key_word = r_widx[0] ? key_pair[31:0] : key_pair[63:32];

    // word unit: temp from the previous word, xor with the word nk back
    always_comb begin
        t_word = r_last;
        if (r_pos == 3'd0) begin
            t_word = aes_kx_pkg::sub_word(aes_kx_pkg::rot_word(r_last))
                     ^ {aes_kx_pkg::RCON[r_rc_idx], 24'd0};
        end else if (r_nk == aes_kx_pkg::NK_256 && r_pos == 3'd4) begin
            t_word = aes_kx_pkg::sub_word(r_last);
        end
        new_word = r_rdata ^ t_word;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_bytes <= aes_kx_pkg::KEY_BYTES_RST;
            for (int j = 0; j < 4; j++) begin
                r_key[j] <= '0;
            end
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                aes_kx_pkg::CFG_KEY_BYTES: r_key_bytes <= i_cfg_data[5:0];
                aes_kx_pkg::CFG_KEY_01:    r_key[0] <= i_cfg_data;
                aes_kx_pkg::CFG_KEY_23:    r_key[1] <= i_cfg_data;
                aes_kx_pkg::CFG_KEY_45:    r_key[2] <= i_cfg_data;
                aes_kx_pkg::CFG_KEY_67:    r_key[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_state     = r_state;
        n_widx      = r_widx;
        n_limit     = r_limit;
        n_base      = r_base;
        n_pos       = r_pos;
        n_k         = r_k;
        n_rc_idx    = r_rc_idx;
        n_nk        = r_nk;
        n_last      = r_last;
        n_mark      = r_mark;
        n_rounds    = r_rounds;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        mem_we      = 1'b0;
        mem_waddr   = r_widx;
        mem_wdata   = key_word;
        mem_raddr   = r_widx + WIDX_W'(1) - WIDX_W'(r_nk);
        o_in_ready  = (r_state == aes_kx_pkg::S_IDLE);

        unique case (r_state)
            aes_kx_pkg::S_IDLE: begin
                if (in_fire) begin
                    n_res             = '0;
                    n_res.round_count = nr;
                    n_res.status      = aes_kx_pkg::STATUS_OK;
                    n_state           = aes_kx_pkg::S_RESP;
                    if (nr == aes_kx_pkg::ROUNDS_BAD) begin
                        n_res.status = aes_kx_pkg::STATUS_BAD_LEN;
                        if (i_in.req_type == aes_kx_pkg::REQ_EXPAND) begin
                            n_mark   = 1'b0;
                            n_rounds = '0;
                        end
                    end else if (i_in.req_type == aes_kx_pkg::REQ_EXPAND) begin
                        n_nk     = nk_new;
                        n_limit  = (total > DEPTH8) ? DEPTH - WIDX_W'(1)
                                                    : WIDX_W'(total - 8'd1);
                        n_widx   = '0;
                        n_pos    = '0;
                        n_rc_idx = 4'd1;
                        n_state  = aes_kx_pkg::S_LOAD;
                    end else if (!r_mark) begin
                        n_res.status = aes_kx_pkg::STATUS_NOT_EXP;
                    end else if (i_in.round_index > r_rounds || rd_end > DEPTH8) begin
                        n_res.status = aes_kx_pkg::STATUS_RANGE;
                    end else begin
                        n_base  = WIDX_W'({i_in.round_index, 2'b00});
                        n_k     = '0;
                        n_state = aes_kx_pkg::S_READ;
                    end
                end
            end
            aes_kx_pkg::S_LOAD: begin
                mem_we    = 1'b1;
                mem_wdata = key_word;
                n_last    = key_word;
                n_widx    = r_widx + WIDX_W'(1);
                n_pos     = r_pos + 3'd1;
                if (r_widx == WIDX_W'(r_nk - 4'd1)) begin
                    n_pos   = '0;
                    n_state = aes_kx_pkg::S_EXPAND;
                end
            end
            aes_kx_pkg::S_EXPAND: begin
                mem_we    = 1'b1;
                mem_wdata = new_word;
                n_last    = new_word;
                n_widx    = r_widx + WIDX_W'(1);
                n_pos     = (r_pos == 3'(r_nk - 4'd1)) ? 3'd0 : r_pos + 3'd1;
                if (r_pos == 3'd0) begin
                    n_rc_idx = r_rc_idx + 4'd1;
                end
                if (r_widx == r_limit) begin
                    n_mark   = 1'b1;
                    n_rounds = r_nk + aes_kx_pkg::NK_OFFSET;
                    n_state  = aes_kx_pkg::S_RESP;
                end
            end
            aes_kx_pkg::S_READ: begin
                mem_raddr = r_base + WIDX_W'(r_k[1:0]);
                // shift captured words in; the first one ends in word0
                if (r_k != 3'd0) begin
                    n_res.round_word0 = r_res.round_word1;
                    n_res.round_word1 = r_res.round_word2;
                    n_res.round_word2 = r_res.round_word3;
                    n_res.round_word3 = r_rdata;
                end
                n_k = r_k + 3'd1;
                if (r_k == 3'd4) begin
                    n_state = aes_kx_pkg::S_RESP;
                end
            end
            aes_kx_pkg::S_RESP: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = aes_kx_pkg::S_IDLE;
                end
            end
            default: n_state = aes_kx_pkg::S_IDLE;
        endcase

        // any write to a configuration register (index 0 to 4) drops the expanded mark
        if (cfg_hit) begin
            n_mark = 1'b0;
        end
    end

    assign mem_re = (mem_raddr < DEPTH);

    always_ff @(posedge i_clk) begin
        if (mem_we && mem_waddr < DEPTH) begin
            r_mem[mem_waddr[ADDR_W-1:0]] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_raddr[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= aes_kx_pkg::S_IDLE;
            r_mark      <= 1'b0;
            r_rounds    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_mark      <= n_mark;
            r_rounds    <= n_rounds;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_widx   <= n_widx;
        r_limit  <= n_limit;
        r_base   <= n_base;
        r_pos    <= n_pos;
        r_k      <= n_k;
        r_rc_idx <= n_rc_idx;
        r_nk     <= n_nk;
        r_last   <= n_last;
        r_res    <= n_res;
        r_out    <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_write_in_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == aes_kx_pkg::S_EXPAND) |-> (r_widx <= r_limit && r_limit < DEPTH))
        else $error("schedule write past the last schedule word");

    a_expand_sets_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == aes_kx_pkg::S_EXPAND && r_widx == r_limit && !cfg_hit)
        |=> (r_mark && r_state == aes_kx_pkg::S_RESP))
        else $error("finished expand did not set the expanded mark");

    a_read_needs_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == aes_kx_pkg::S_READ) |-> (r_rounds != aes_kx_pkg::ROUNDS_BAD))
        else $error("round key read without a stored schedule");

    a_cfg_clears_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_hit |=> !r_mark)
        else $error("register write left the expanded mark set");

    a_out_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == aes_kx_pkg::S_RESP && r_out_valid && !i_out_ready)
        |=> (r_state == aes_kx_pkg::S_RESP))
        else $error("result dropped while the output was stalled");

endmodule

`default_nettype wire

@@ dv/aes_key_expansion_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the AES key expansion block: schedule predictor and scoreboard.

module aes_key_expansion_tb;

    localparam int SCHED_DEPTH  = aes_kx_pkg::SCHEDULE_WORDS_DEF;
    localparam int RANDOM_ITEMS = 1250;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 70;

    typedef enum logic { ROW_CFG, ROW_REQ } t_row_kind;

    typedef struct {
        t_row_kind                         kind;
        logic [aes_kx_pkg::CFG_IDX_W-1:0]  idx;
        logic [aes_kx_pkg::CFG_DATA_W-1:0] data;
        aes_kx_pkg::t_req                  req;
        bit                                typed;
        aes_kx_pkg::t_result               want;
    } t_plan_row;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n;
    logic                              i_in_valid;
    logic                              o_in_ready;
    aes_kx_pkg::t_req                  i_in;
    logic                              o_out_valid;
    logic                              i_out_ready;
    aes_kx_pkg::t_result               o_out;
    logic                              i_cfg_we;
    logic [aes_kx_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [aes_kx_pkg::CFG_DATA_W-1:0] i_cfg_data;

    // Predictor state
    logic [7:0]  sbox_mem [256];
    logic [7:0]  rcon_mem [16];
    logic [5:0]  kx_len;
    logic [63:0] kx_key [4];
    logic [31:0] kx_words [SCHED_DEPTH];
    logic        kx_ready_mark;
    logic [3:0]  kx_rounds;

    aes_kx_pkg::t_result awaited[$];
    aes_kx_pkg::t_result want_res;
    int      mismatches = 0;
    int      answered   = 0;
    int      cycle_count = 0;
    int      burst_left = 0;

    // Receiver pattern state
    bit      press_done = 1'b0;
    int      hold_left  = 0;
    int      rx_mode    = 0;
    int      rx_left    = 0;
    int      rx_tick    = 0;

    aes_key_expansion dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [7:0] xtime(input logic [7:0] b);
        xtime = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        p = 8'h00;
        for (int k = 0; k < 8; k++) begin
            if (b[0]) p = p ^ a;
            a = xtime(a);
            b = b >> 1;
        end
        gf_mul = p;
    endfunction

    function automatic logic [31:0] sub4(input logic [31:0] w);
        sub4 = {sbox_mem[w[31:24]], sbox_mem[w[23:16]], sbox_mem[w[15:8]], sbox_mem[w[7:0]]};
    endfunction

    function automatic logic [3:0] rounds_of(input logic [5:0] kb);
        unique case (kb)
            aes_kx_pkg::KEY_BYTES_128: rounds_of = aes_kx_pkg::ROUNDS_128;
            aes_kx_pkg::KEY_BYTES_192: rounds_of = aes_kx_pkg::ROUNDS_192;
            aes_kx_pkg::KEY_BYTES_256: rounds_of = aes_kx_pkg::ROUNDS_256;
            default:                   rounds_of = aes_kx_pkg::ROUNDS_BAD;
        endcase
    endfunction

    // Build the S-box from the field inverse and affine map, and Rcon by doubling
    initial begin
        logic [7:0] inv;
        for (int x = 0; x < 256; x++) begin
            inv = 8'h00;
            for (int y = 1; y < 256; y++) begin
                if (x != 0 && gf_mul(x[7:0], y[7:0]) == 8'h01) inv = y[7:0];
            end
            sbox_mem[x[7:0]] = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]}
                             ^ {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ 8'h63;
        end
        rcon_mem[0] = 8'h00;
        rcon_mem[1] = 8'h01;
        for (int j = 2; j < 16; j++)
            rcon_mem[j[3:0]] = (j <= 10) ? xtime(rcon_mem[4'(j - 1)]) : 8'h00;
    end

    function automatic aes_kx_pkg::t_result kx_answer(input aes_kx_pkg::t_req rq);
        aes_kx_pkg::t_result res;
        logic [3:0]  nr;
        logic [31:0] w [60];
        logic [31:0] t;
        int          nk;
        int          total;
        int          base;
        res = '0;
        nr = rounds_of(kx_len);
        res.round_count = nr;
        if (nr == aes_kx_pkg::ROUNDS_BAD) begin
            res.status = aes_kx_pkg::STATUS_BAD_LEN;
            if (rq.req_type == aes_kx_pkg::REQ_EXPAND) begin
                kx_ready_mark = 1'b0;
                kx_rounds = 4'd0;
            end
        end else if (rq.req_type == aes_kx_pkg::REQ_EXPAND) begin
            nk = int'(nr) - 6;
            total = (int'(nr) + 1) * 4;
            for (int i = 0; i < nk; i++)
                w[6'(i)] = i[0] ? kx_key[2'(i >> 1)][31:0] : kx_key[2'(i >> 1)][63:32];
            for (int i = nk; i < total && i < 60; i++) begin
                t = w[6'(i - 1)];
                if (i % nk == 0) begin
                    t = sub4({t[23:0], t[31:24]}) ^ {rcon_mem[4'(i / nk)], 24'h0};
                end else if (nk > 6 && i % nk == 4) begin
                    t = sub4(t);
                end
                w[6'(i)] = w[6'(i - nk)] ^ t;
            end
            for (int i = 0; i < total && i < 60 && i < SCHED_DEPTH; i++)
                kx_words[6'(i)] = w[6'(i)];
            kx_ready_mark = 1'b1;
            kx_rounds = nr;
            res.status = aes_kx_pkg::STATUS_OK;
        end else if (!kx_ready_mark) begin
            res.status = aes_kx_pkg::STATUS_NOT_EXP;
        end else if (rq.round_index > kx_rounds
                     || (int'(rq.round_index) + 1) * 4 > SCHED_DEPTH) begin
            res.status = aes_kx_pkg::STATUS_RANGE;
        end else begin
            base = int'(rq.round_index) * 4;
            res.round_word0 = kx_words[6'((base + 0) % SCHED_DEPTH)];
            res.round_word1 = kx_words[6'((base + 1) % SCHED_DEPTH)];
            res.round_word2 = kx_words[6'((base + 2) % SCHED_DEPTH)];
            res.round_word3 = kx_words[6'((base + 3) % SCHED_DEPTH)];
            res.status = aes_kx_pkg::STATUS_OK;
        end
        return res;
    endfunction

    task automatic flag(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        mismatches++;
    endtask

    task automatic cmp(input string field, input logic [31:0] got, input logic [31:0] want);
        if (got !== want) flag($sformatf("%s got %h want %h", field, got, want));
    endtask

    // Scoreboard: compare every output transfer with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (awaited.size() == 0) begin
                flag("result transfer with nothing awaited");
            end else begin
                want_res = awaited.pop_front();
                cmp("round_word0", o_out.round_word0, want_res.round_word0);
                cmp("round_word1", o_out.round_word1, want_res.round_word1);
                cmp("round_word2", o_out.round_word2, want_res.round_word2);
                cmp("round_word3", o_out.round_word3, want_res.round_word3);
                cmp("round_count", 32'(o_out.round_count), 32'(want_res.round_count));
                cmp("status", 32'(o_out.status), 32'(want_res.status));
                answered++;
            end
        end
    end

    // Receiver: switch between stall patterns, plus one long hold-off under load
    always @(negedge i_clk) begin
        if (!press_done && answered >= 150 && i_in_valid) begin
            hold_left = 400;
            press_done = 1'b1;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready = 1'b0;
        end else begin
            if (rx_left == 0) begin
                rx_mode = $urandom_range(0, 3);
                rx_left = $urandom_range(20, 200);
            end
            rx_left--;
            rx_tick++;
            case (rx_mode)
                0:       i_out_ready = 1'b1;
                1:       i_out_ready = 1'($urandom_range(0, 1));
                2:       i_out_ready = (rx_tick % 4 == 0);
                default: i_out_ready = ($urandom_range(0, 9) == 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Offer one request in bursts with random gaps; predict on transfer
    task automatic offer(input aes_kx_pkg::t_req rq, input bit typed,
                         input aes_kx_pkg::t_result want);
        int                  gap;
        aes_kx_pkg::t_result res;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            case ($urandom_range(0, 5))
                0, 1:    gap = 0;
                2:       gap = $urandom_range(20, 40);
                default: gap = $urandom_range(1, 8);
            endcase
            if (gap > 0) begin
                i_in_valid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        i_in = rq;
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        res = kx_answer(rq);
        awaited.push_back(typed ? want : res);
        burst_left--;
        @(negedge i_clk);
    endtask

    // Drop valid and wait until every result is back
    task automatic settle();
        i_in_valid = 1'b0;
        while (awaited.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic cfg_put(input logic [aes_kx_pkg::CFG_IDX_W-1:0] idx,
                           input logic [aes_kx_pkg::CFG_DATA_W-1:0] data);
        i_cfg_we = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = data;
        unique case (idx)
            aes_kx_pkg::CFG_KEY_BYTES: kx_len = data[5:0];
            aes_kx_pkg::CFG_KEY_01:    kx_key[0] = data;
            aes_kx_pkg::CFG_KEY_23:    kx_key[1] = data;
            aes_kx_pkg::CFG_KEY_45:    kx_key[2] = data;
            aes_kx_pkg::CFG_KEY_67:    kx_key[3] = data;
            default:                   ;
        endcase
        if (idx <= aes_kx_pkg::CFG_KEY_67) kx_ready_mark = 1'b0;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    function automatic t_plan_row cfg_row(input logic [aes_kx_pkg::CFG_IDX_W-1:0] idx,
                                          input logic [aes_kx_pkg::CFG_DATA_W-1:0] data);
        t_plan_row r;
        r = '{ROW_CFG, idx, data, '0, 1'b0, '0};
        return r;
    endfunction

    function automatic t_plan_row req_row(input logic rt, input logic [3:0] ri);
        t_plan_row r;
        r = '{ROW_REQ, '0, '0, '0, 1'b0, '0};
        r.req.req_type = rt;
        r.req.round_index = ri;
        return r;
    endfunction

    function automatic t_plan_row err_row(input logic rt, input logic [3:0] ri,
                                          input logic [3:0] cnt, input logic [1:0] st);
        t_plan_row r;
        r = req_row(rt, ri);
        r.typed = 1'b1;
        r.want.round_count = cnt;
        r.want.status = st;
        return r;
    endfunction

    function automatic t_plan_row kat_row(input logic [3:0] ri, input logic [127:0] words,
                                          input logic [3:0] cnt);
        t_plan_row r;
        r = err_row(aes_kx_pkg::REQ_READ, ri, cnt, aes_kx_pkg::STATUS_OK);
        {r.want.round_word0, r.want.round_word1,
         r.want.round_word2, r.want.round_word3} = words;
        return r;
    endfunction

    initial begin
        t_plan_row        plan[$];
        aes_kx_pkg::t_req rq;
        logic [3:0]       nr;
        logic [63:0]      data;
        int               issued;
        int               phase_items;

        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in = '0;
        i_out_ready = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        kx_len = aes_kx_pkg::KEY_BYTES_RST;
        kx_key = '{default: '0};
        kx_ready_mark = 1'b0;
        kx_rounds = 4'd0;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Zero key after reset, range edges
        plan.push_back(err_row(aes_kx_pkg::REQ_READ, 4'd0, aes_kx_pkg::ROUNDS_128,
                               aes_kx_pkg::STATUS_NOT_EXP));
        plan.push_back(req_row(aes_kx_pkg::REQ_EXPAND, 4'd0));
        plan.push_back(req_row(aes_kx_pkg::REQ_READ, 4'd0));
        plan.push_back(req_row(aes_kx_pkg::REQ_READ, 4'd10));
        plan.push_back(err_row(aes_kx_pkg::REQ_READ, 4'd11, aes_kx_pkg::ROUNDS_128,
                               aes_kx_pkg::STATUS_RANGE));
        plan.push_back(err_row(aes_kx_pkg::REQ_READ, 4'd15, aes_kx_pkg::ROUNDS_128,
                               aes_kx_pkg::STATUS_RANGE));
        // 128-bit known answer; a key write clears the expanded mark
        plan.push_back(cfg_row(aes_kx_pkg::CFG_KEY_01, 64'h2b7e1516_28aed2a6));
        plan.push_back(cfg_row(aes_kx_pkg::CFG_KEY_23, 64'habf71588_09cf4f3c));
        plan.push_back(err_row(aes_kx_pkg::REQ_READ, 4'd0, aes_kx_pkg::ROUNDS_128,
                               aes_kx_pkg::STATUS_NOT_EXP));
        plan.push_back(req_row(aes_kx_pkg::REQ_EXPAND, 4'd0));
        plan.push_back(kat_row(4'd10, 128'hd014f9a8_c9ee2589_e13f0cc8_b6630ca6,
                               aes_kx_pkg::ROUNDS_128));
        // Zero key length
        plan.push_back(cfg_row(aes_kx_pkg::CFG_KEY_BYTES, 64'd0));
        plan.push_back(err_row(aes_kx_pkg::REQ_READ, 4'd3, aes_kx_pkg::ROUNDS_BAD,
                               aes_kx_pkg::STATUS_BAD_LEN));
        plan.push_back(err_row(aes_kx_pkg::REQ_EXPAND, 4'd0, aes_kx_pkg::ROUNDS_BAD,
                               aes_kx_pkg::STATUS_BAD_LEN));
        plan.push_back(cfg_row(aes_kx_pkg::CFG_KEY_BYTES, 64'd16));
        plan.push_back(err_row(aes_kx_pkg::REQ_READ, 4'd0, aes_kx_pkg::ROUNDS_128,
                               aes_kx_pkg::STATUS_NOT_EXP));
        // 256-bit known answer
        plan.push_back(cfg_row(aes_kx_pkg::CFG_KEY_BYTES, 64'd32));
        plan.push_back(cfg_row(aes_kx_pkg::CFG_KEY_01, 64'h603deb10_15ca71be));
        plan.push_back(cfg_row(aes_kx_pkg::CFG_KEY_23, 64'h2b73aef0_857d7781));
        plan.push_back(cfg_row(aes_kx_pkg::CFG_KEY_45, 64'h1f352c07_3b6108d7));
        plan.push_back(cfg_row(aes_kx_pkg::CFG_KEY_67, 64'h2d9810a3_0914dff4));
        plan.push_back(req_row(aes_kx_pkg::REQ_EXPAND, 4'd0));
        plan.push_back(kat_row(4'd14, 128'hfe4890d1_e6188d0b_046df344_706c631e,
                               aes_kx_pkg::ROUNDS_256));
        plan.push_back(err_row(aes_kx_pkg::REQ_READ, 4'd15, aes_kx_pkg::ROUNDS_256,
                               aes_kx_pkg::STATUS_RANGE));
        plan.push_back(req_row(aes_kx_pkg::REQ_READ, 4'd0));
        // Write past the register list leaves the schedule usable
        plan.push_back(cfg_row(3'd7, 64'hffff_ffff_ffff_ffff));
        plan.push_back(req_row(aes_kx_pkg::REQ_READ, 4'd7));
        // 192-bit, all-ones key
        plan.push_back(cfg_row(aes_kx_pkg::CFG_KEY_BYTES, 64'd24));
        plan.push_back(cfg_row(aes_kx_pkg::CFG_KEY_01, 64'hffff_ffff_ffff_ffff));
        plan.push_back(cfg_row(aes_kx_pkg::CFG_KEY_23, 64'hffff_ffff_ffff_ffff));
        plan.push_back(cfg_row(aes_kx_pkg::CFG_KEY_45, 64'hffff_ffff_ffff_ffff));
        plan.push_back(req_row(aes_kx_pkg::REQ_EXPAND, 4'd15));
        plan.push_back(req_row(aes_kx_pkg::REQ_READ, 4'd12));
        plan.push_back(err_row(aes_kx_pkg::REQ_READ, 4'd13, aes_kx_pkg::ROUNDS_192,
                               aes_kx_pkg::STATUS_RANGE));
        // Largest length code, then upper data bits ignored
        plan.push_back(cfg_row(aes_kx_pkg::CFG_KEY_BYTES, 64'hffff_ffff_ffff_ffff));
        plan.push_back(err_row(aes_kx_pkg::REQ_EXPAND, 4'd0, aes_kx_pkg::ROUNDS_BAD,
                               aes_kx_pkg::STATUS_BAD_LEN));
        plan.push_back(err_row(aes_kx_pkg::REQ_READ, 4'd0, aes_kx_pkg::ROUNDS_BAD,
                               aes_kx_pkg::STATUS_BAD_LEN));
        plan.push_back(cfg_row(aes_kx_pkg::CFG_KEY_BYTES, 64'hffff_ffff_ffff_ffd0));
        plan.push_back(err_row(aes_kx_pkg::REQ_READ, 4'd0, aes_kx_pkg::ROUNDS_128,
                               aes_kx_pkg::STATUS_NOT_EXP));
        plan.push_back(req_row(aes_kx_pkg::REQ_EXPAND, 4'd0));
        plan.push_back(req_row(aes_kx_pkg::REQ_READ, 4'd10));

        foreach (plan[n]) begin
            if (plan[n].kind == ROW_CFG) begin
                settle();
                cfg_put(plan[n].idx, plan[n].data);
            end else begin
                offer(plan[n].req, plan[n].typed, plan[n].want);
            end
        end

        issued = 0;
        while (issued < RANDOM_ITEMS) begin
            settle();
            if ($urandom_range(0, 9) < 7) begin
                data = {$urandom, $urandom};
                case ($urandom_range(0, 9))
                    0, 1, 2: data[5:0] = aes_kx_pkg::KEY_BYTES_128;
                    3, 4, 5: data[5:0] = aes_kx_pkg::KEY_BYTES_192;
                    6, 7, 8: data[5:0] = aes_kx_pkg::KEY_BYTES_256;
                    default: data[5:0] = 6'($urandom_range(0, 63));
                endcase
                cfg_put(aes_kx_pkg::CFG_KEY_BYTES, data);
            end
            for (int k = 1; k <= 4; k++)
                if ($urandom_range(0, 9) < 6)
                    cfg_put(k[aes_kx_pkg::CFG_IDX_W-1:0], {$urandom, $urandom});
            if ($urandom_range(0, 9) == 0)
                cfg_put(aes_kx_pkg::CFG_IDX_W'($urandom_range(5, 7)), {$urandom, $urandom});

            phase_items = $urandom_range(8, 40);
            for (int k = 0; k < phase_items; k++) begin
                nr = rounds_of(kx_len);
                if (k == 0)
                    rq.req_type = ($urandom_range(0, 19) < 17) ? aes_kx_pkg::REQ_EXPAND
                                                                : aes_kx_pkg::REQ_READ;
                else
                    rq.req_type = ($urandom_range(0, 15) == 0) ? aes_kx_pkg::REQ_EXPAND
                                                                : aes_kx_pkg::REQ_READ;
                if (nr != aes_kx_pkg::ROUNDS_BAD && $urandom_range(0, 4) != 0)
                    rq.round_index = 4'($urandom_range(0, nr));
                else
                    rq.round_index = 4'($urandom_range(0, 15));
                offer(rq, 1'b0, '0);
                issued++;
            end
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && awaited.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
